[hdl/ofe_pkg.sv]
// Shared types and constants for the three-axis One Euro filter.
// No dependencies; the other files that use it refer to it by scoped names.
package ofe_pkg;

  localparam int SW = 24;                 // sample width
  localparam int AXES = 3;
  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int DTW = 20;                // time step width
  localparam int CFGW = 16;               // config register width

  localparam logic [DTW-1:0] DEFAULT_DT_US = DTW'(16667);
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [20:0] US_PER_S = 21'd1000000;
  // 2^24 * 1e6 and that times 2^16
  localparam logic [63:0] ALPHA_D = 64'd16777216000000;
  localparam logic [63:0] ALPHA_DQ = 64'd1099511627776000000;
  localparam logic [23:0] FC_MAX = 24'hFFFFFF;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [5:0] ALPHA_STEPS = 6'd17;
  localparam logic [5:0] VEL_STEPS = 6'd32;

  typedef enum logic [1:0] {
    CFG_MIN_CUTOFF   = 2'd0,
    CFG_BETA_GAIN    = 2'd1,
    CFG_DERIV_CUTOFF = 2'd2
  } cfg_idx_t;

  // divider launch request
  typedef struct packed {
    logic       start;
    logic [5:0] steps;
  } div_req_t;

endpackage

[hdl/ofe_if.sv]
// Stream channel interfaces for the filter's sample input and result output.
// Depends on ofe_pkg for the sample and time step widths.
interface ofe_in_if;
  logic valid;
  logic ready;
  logic signed [ofe_pkg::SW-1:0] pos_x;
  logic signed [ofe_pkg::SW-1:0] pos_y;
  logic signed [ofe_pkg::SW-1:0] pos_z;
  logic [ofe_pkg::DTW-1:0] dt_us;
  modport source(output valid, pos_x, pos_y, pos_z, dt_us, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, dt_us, output ready);
endinterface

interface ofe_out_if;
  logic valid;
  logic ready;
  logic signed [ofe_pkg::SW-1:0] out_x;
  logic signed [ofe_pkg::SW-1:0] out_y;
  logic signed [ofe_pkg::SW-1:0] out_z;
  modport source(output valid, out_x, out_y, out_z, input ready);
  modport sink(input valid, out_x, out_y, out_z, output ready);
endinterface

[hdl/one_euro_filter_3axis.sv]
// Top level of the three-axis One Euro filter: sequencer around one
// multiplier and one divider. Depends on ofe_pkg, ofe_if, ofe_mul, ofe_div.

// One Euro adaptive low-pass filter on three signed 24-bit axes that share a
// microsecond time step (zero means 16667 us). The first sample after reset
// passes straight through. Each later sample is paced by the bit-serial
// divider: a 17-step division for each smoothing factor (one for velocity,
// one per axis for position) and a 32-step velocity division per axis,
// skipped when the velocity saturates. in_ch.ready is high only while the
// sequencer is idle; a finished result waits in the output register while
// the next sample is taken. The user must write registers through cfg_we/
// cfg_index/cfg_data only while idle; the block does not enforce this.
module one_euro_filter_3axis (
  input  logic                     clk,
  input  logic                     rst,
  ofe_in_if.sink                   in_ch,
  ofe_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [ofe_pkg::CFGW-1:0] cfg_data
);

  localparam int SW = ofe_pkg::SW;
  localparam int AX = ofe_pkg::AXES;
  localparam int AXW = ofe_pkg::AXW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MDT, ST_SDT, ST_AMUL, ST_ADIV, ST_AWAIT,
    ST_VMUL, ST_VDIV, ST_VWAIT, ST_RMUL, ST_RUPD, ST_BMUL, ST_BFC,
    ST_YMUL, ST_YUPD, ST_FIN
  } state_t;

  state_t state;

  logic [15:0] min_cutoff, beta_gain, deriv_cutoff;
  logic               started;
  logic signed [SW-1:0] prev_pos [AX];
  logic signed [31:0]   prev_rate [AX];
  logic signed [SW-1:0] xs [AX];
  logic signed [SW-1:0] res [AX];
  logic [AXW-1:0]       axis;
  logic [ofe_pkg::DTW-1:0] dt;
  logic [38:0]          dtk;
  logic [23:0]          fc;
  logic                 phase;
  logic [16:0]          ad, ap;
  logic signed [31:0]   v, r;
  logic                 vsign;

  // multiplier and divider
  logic signed [39:0] ma;
  logic signed [24:0] mb;
  logic signed [64:0] mprod;
  ofe_pkg::div_req_t  dreq;
  logic [63:0]        ddividend;
  logic [79:0]        ddivisor;
  logic [31:0]        dquot;
  logic               ddone;

  ofe_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mprod));

  ofe_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .dividend(ddividend),
    .divisor(ddivisor), .quotient(dquot), .done(ddone)
  );

  // datapath helpers
  logic signed [SW:0]  dpos;
  logic signed [32:0]  diffr;
  logic [31:0]         rmag;
  logic signed [45:0]  vprod;
  logic [45:0]         vmag;
  logic                vovf;
  logic [63:0]         asum, anum;
  logic signed [64:0]  rround;
  logic [48:0]         bt;
  logic [41:0]         fsum;
  logic signed [31:0]  vq;
  logic [ofe_pkg::DTW-1:0] dt_in;

  always_comb begin
    dpos  = (SW+1)'(xs[axis]) - (SW+1)'(prev_pos[axis]);
    diffr = 33'(v) - 33'(prev_rate[axis]);
    rmag  = r[31] ? 32'(-r) : 32'(r);
    vprod = mprod[45:0];
    vmag  = vprod[45] ? 46'(-vprod) : 46'(vprod);
    vovf  = {6'b0, vmag} >= {dt, 32'b0};
    asum  = mprod[63:0] + ofe_pkg::ALPHA_D;
    anum  = ofe_pkg::ALPHA_DQ + {1'b0, asum[63:1]};
    rround = (mprod + 65'sd32768) >>> 16;
    bt    = {1'b0, mprod[47:0]} + 49'd128;
    fsum  = {26'b0, min_cutoff} + {1'b0, bt[48:8]};
    dt_in = (in_ch.dt_us == '0) ? ofe_pkg::DEFAULT_DT_US : in_ch.dt_us;
    // signed saturation of the velocity quotient
    if (vsign) vq = dquot[31] ? 32'sh80000000 : 32'(-$signed(dquot));
    else       vq = dquot[31] ? 32'sh7FFFFFFF : $signed(dquot);
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_MDT:  begin ma = 40'(dt); mb = 25'(ofe_pkg::TWO_PI_Q16); end
      ST_AMUL: begin ma = {1'b0, dtk}; mb = {1'b0, fc}; end
      ST_VMUL: begin ma = 40'(dpos); mb = 25'(ofe_pkg::US_PER_S); end
      ST_RMUL: begin ma = 40'(diffr); mb = {8'b0, ad}; end
      ST_BMUL: begin ma = {8'b0, rmag}; mb = {9'b0, beta_gain}; end
      ST_YMUL: begin ma = 40'(dpos); mb = {8'b0, ap}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // divider launch
  always_comb begin
    dreq      = '0;
    ddividend = {18'b0, vmag};
    ddivisor  = {29'b0, dt, 31'b0};
    if (state == ST_ADIV) begin
      dreq.start = 1'b1;
      dreq.steps = ofe_pkg::ALPHA_STEPS;
      ddividend  = anum;
      ddivisor   = {asum, 16'b0};
    end else if (state == ST_VDIV && !vovf) begin
      dreq.start = 1'b1;
      dreq.steps = ofe_pkg::VEL_STEPS;
    end
  end

  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.out_x = res[0];
  assign out_ch.out_y = res[(AX > 1) ? 1 : 0];
  assign out_ch.out_z = res[(AX > 2) ? 2 : 0];

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      started      <= 1'b0;
      out_ch.valid <= 1'b0;
      min_cutoff   <= 16'd256;
      beta_gain    <= 16'd1966;
      deriv_cutoff <= 16'd256;
      for (int i = 0; i < AX; i++) begin
        prev_pos[i]  <= '0;
        prev_rate[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ofe_pkg::CFG_MIN_CUTOFF:   min_cutoff   <= cfg_data;
          ofe_pkg::CFG_BETA_GAIN:    beta_gain    <= cfg_data;
          ofe_pkg::CFG_DERIV_CUTOFF: deriv_cutoff <= cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready && state != ST_FIN) out_ch.valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            xs[0] <= in_ch.pos_x;
            if (AX > 1) xs[(AX > 1) ? 1 : 0] <= in_ch.pos_y;
            if (AX > 2) xs[(AX > 2) ? 2 : 0] <= in_ch.pos_z;
            dt   <= dt_in;
            axis <= '0;
            if (!started) begin
              // first sample seeds the state and passes through
              started <= 1'b1;
              prev_pos[0] <= in_ch.pos_x;
              if (AX > 1) prev_pos[(AX > 1) ? 1 : 0] <= in_ch.pos_y;
              if (AX > 2) prev_pos[(AX > 2) ? 2 : 0] <= in_ch.pos_z;
              for (int i = 0; i < AX; i++) prev_rate[i] <= '0;
              state <= ST_FIN;
            end else begin
              state <= ST_MDT;
            end
          end
        end
        ST_MDT: state <= ST_SDT;
        ST_SDT: begin
          dtk   <= mprod[38:0];
          fc    <= {8'b0, deriv_cutoff};
          phase <= 1'b0;
          state <= ST_AMUL;
        end
        ST_AMUL: state <= ST_ADIV;
        ST_ADIV: state <= ST_AWAIT;
        ST_AWAIT: begin
          if (ddone) begin
            if (phase) begin
              ap    <= ofe_pkg::ONE_Q16 - dquot[16:0];
              state <= ST_YMUL;
            end else begin
              ad    <= ofe_pkg::ONE_Q16 - dquot[16:0];
              state <= ST_VMUL;
            end
          end
        end
        ST_VMUL: state <= ST_VDIV;
        ST_VDIV: begin
          vsign <= vprod[45];
          if (vovf) begin
            v     <= vprod[45] ? 32'sh80000000 : 32'sh7FFFFFFF;
            state <= ST_RMUL;
          end else begin
            state <= ST_VWAIT;
          end
        end
        ST_VWAIT: begin
          if (ddone) begin
            v     <= vq;
            state <= ST_RMUL;
          end
        end
        ST_RMUL: state <= ST_RUPD;
        ST_RUPD: begin
          r     <= prev_rate[axis] + rround[31:0];
          state <= ST_BMUL;
        end
        ST_BMUL: state <= ST_BFC;
        ST_BFC: begin
          // cutoff rises with smoothed speed, saturated
          fc    <= (fsum > {18'b0, ofe_pkg::FC_MAX}) ? ofe_pkg::FC_MAX : fsum[23:0];
          phase <= 1'b1;
          state <= ST_AMUL;
        end
        ST_YMUL: state <= ST_YUPD;
        ST_YUPD: begin
          prev_pos[axis]  <= prev_pos[axis] + rround[SW-1:0];
          prev_rate[axis] <= r;
          fc    <= {8'b0, deriv_cutoff};
          if (axis == AXW'(AX - 1)) begin
            state <= ST_FIN;
          end else begin
            axis  <= axis + AXW'(1);
            state <= ST_VMUL;
          end
        end
        ST_FIN: begin
          // hold until the output register is free, then load the new positions
          if (!out_ch.valid || out_ch.ready) begin
            for (int i = 0; i < AX; i++) res[i] <= prev_pos[i];
            out_ch.valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/ofe_mul.sv]
// Shared signed multiplier with a registered product.
// No package dependencies.
module ofe_mul (
  input  logic               clk,
  input  logic signed [39:0] a,
  input  logic signed [24:0] b,
  output logic signed [64:0] p
);

  always_ff @(posedge clk) begin
    p <= 65'(a) * 65'(b);
  end

endmodule

[hdl/ofe_div.sv]
// Restoring divider, one quotient bit per cycle, pre-shifted divisor.
// Depends on ofe_pkg for the request struct.
module ofe_div (
  input  logic              clk,
  input  logic              rst,
  input  ofe_pkg::div_req_t req,
  input  logic [63:0]       dividend,
  input  logic [79:0]       divisor,
  output logic [31:0]       quotient,
  output logic              done
);

  logic [63:0] rem;
  logic [79:0] dsh;
  logic [5:0]  cnt;
  logic        ge;

  assign ge = {16'b0, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem      <= dividend;
        dsh      <= divisor;
        cnt      <= req.steps;
        quotient <= '0;
      end else if (cnt != 6'd0) begin
        if (ge) rem <= rem - dsh[63:0];
        quotient <= {quotient[30:0], ge};
        dsh      <= dsh >> 1;
        cnt      <= cnt - 6'd1;
        if (cnt == 6'd1) done <= 1'b1;
      end
    end
  end

endmodule
